// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL; vsfp_core.sv includes them.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked at every rising edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/core/vsfp_pkg.sv
package vsfp_pkg;

    // Number of 128,0 pairs that make up the preamble.
    localparam int PREAMBLE_PAIRS = 4;
    localparam logic [4:0] PREAMBLE_LEN = 5'(2 * PREAMBLE_PAIRS);

    // Preamble byte values.
    localparam logic [7:0] PRE_HIGH = 8'h80;
    localparam logic [7:0] PRE_LOW  = 8'h00;

    // Frame phase codes.
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_TYPE = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;

    // Frame type codes.
    localparam logic [7:0] FT_WAVE   = 8'd1;
    localparam logic [7:0] FT_HEART  = 8'd2;
    localparam logic [7:0] FT_BREATH = 8'd3;

    // Reset value of the trailer length register.
    localparam logic [1:0] TRAILER_RESET = 2'd2;

    // One parsed result.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] heart_wave;
        logic signed [15:0] breath_wave;
        logic signed [15:0] move_wave;
        logic [7:0]         heart_bpm;
        logic [7:0]         heart_quality;
        logic [7:0]         breath_bpm;
        logic [7:0]         breath_quality;
    } vsfp_result_t;

    // Hand-off between two pipeline stages.
    typedef struct packed {
        logic valid;
        logic ready;
    } vsfp_flow_t;

endpackage

// File: rtl/core/vsfp_in_stage.sv
module vsfp_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    input  logic                take,
    output vsfp_pkg::vsfp_flow_t flow,
    output logic [7:0]          item_byte
);
    import vsfp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       fire;

    // The stage frees up whenever its byte moves on to the parser.
    assign s_tready = !valid_reg || take;
    assign fire     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the byte of each input transfer.
    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_reg <= s_tdata;
        end
    end

    assign flow.valid = valid_reg;
    assign flow.ready = s_tready;
    assign item_byte  = byte_reg;

endmodule

// File: rtl/core/vsfp_core.sv
`include "assert_macros.svh"

module vsfp_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    input  logic                  strobe,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output vsfp_pkg::vsfp_result_t res
);
    import vsfp_pkg::*;

    logic [1:0]         trailer_reg;
    logic [2:0]         phase_reg, phase_next;
    logic [3:0]         count_reg, count_next;
    logic [7:0]         type_reg, type_next;
    logic [8:0]         left_reg, left_next;
    logic [2:0]         idx_reg, idx_next;
    logic [7:0]         high_reg, high_next;
    logic [15:0]        wave_reg [3];
    logic [15:0]        wave_next [3];
    logic [7:0]         rate_reg [4];
    logic [7:0]         rate_next [4];
    logic [7:0]         want;
    logic [4:0]         count_inc;
    logic               finish;
    logic               take_pl;
    logic [1:0]         rate_base;
    logic [8:0]         trailer_ext;

    assign trailer_ext = {7'd0, trailer_reg};
    assign want        = count_reg[0] ? PRE_LOW : PRE_HIGH;
    assign count_inc   = {1'b0, count_reg} + 5'd1;
    assign rate_base   = (type_reg == FT_HEART) ? 2'd0 : 2'd2;

    // Next state for one byte.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        type_next  = type_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        high_next  = high_reg;
        wave_next  = wave_reg;
        rate_next  = rate_reg;
        finish     = 1'b0;
        take_pl    = 1'b0;
        if (strobe) begin
            case (phase_reg)
                PH_TYPE: begin
                    type_next  = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    left_next  = {1'b0, rx_byte} + trailer_ext;
                    idx_next   = 3'd0;
                    high_next  = 8'd0;
                    phase_next = PH_BODY;
                    finish     = (left_next == 9'd0);
                end
                PH_BODY: begin
                    take_pl = (left_reg > trailer_ext);
                    if (left_reg != 9'd0) begin
                        left_next = left_reg - 9'd1;
                    end
                    finish = (left_next == 9'd0);
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (rx_byte == want) begin
                        if (count_inc >= PREAMBLE_LEN) begin
                            count_next = 4'd0;
                            phase_next = PH_TYPE;
                        end else begin
                            count_next = count_inc[3:0];
                        end
                    end else begin
                        count_next = (rx_byte == PRE_HIGH) ? 4'd1 : 4'd0;
                    end
                end
            endcase

            // Payload byte: high byte first for samples, rate then accuracy.
            if (take_pl) begin
                if (type_reg == FT_WAVE) begin
                    if (!idx_reg[0]) begin
                        high_next = rx_byte;
                    end else if (idx_reg <= 3'd5) begin
                        wave_next[idx_reg[2:1]] = {high_reg, rx_byte};
                    end
                end else if (type_reg == FT_HEART || type_reg == FT_BREATH) begin
                    if (idx_reg < 3'd2) begin
                        rate_next[rate_base + {1'b0, idx_reg[0]}] = rx_byte;
                    end
                end
                if (idx_reg < 3'd7) begin
                    idx_next = idx_reg + 3'd1;
                end
            end

            // End of frame returns to the hunt.
            if (finish) begin
                phase_next = PH_HUNT;
                count_next = 4'd0;
                left_next  = 9'd0;
            end
        end
    end

    // A known frame type reports every held value.
    assign res_valid          = finish && (type_reg inside {[FT_WAVE:FT_BREATH]});
    assign res.kind           = 2'(type_reg - 8'd1);
    assign res.heart_wave     = wave_next[0];
    assign res.breath_wave    = wave_next[1];
    assign res.move_wave      = wave_next[2];
    assign res.heart_bpm      = rate_next[0];
    assign res.heart_quality  = rate_next[1];
    assign res.breath_bpm     = rate_next[2];
    assign res.breath_quality = rate_next[3];

    // Parser state and held values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trailer_reg <= TRAILER_RESET;
            phase_reg   <= PH_HUNT;
            count_reg   <= 4'd0;
            type_reg    <= 8'd0;
            left_reg    <= 9'd0;
            idx_reg     <= 3'd0;
            high_reg    <= 8'd0;
            wave_reg    <= '{default: 16'd0};
            rate_reg    <= '{default: 8'd0};
        end else begin
            if (cfg_wr_en) begin
                trailer_reg <= cfg_wr_data;
            end
            phase_reg <= phase_next;
            count_reg <= count_next;
            type_reg  <= type_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            high_reg  <= high_next;
            wave_reg  <= wave_next;
            rate_reg  <= rate_next;
        end
    end

    `ASSERT_CLK(a_res_needs_byte, aclk, aresetn, res_valid |-> strobe)
    `ASSERT_CLK(a_hunt_after_res, aclk, aresetn, res_valid |=> phase_reg == PH_HUNT)
    `ASSERT_CLK(a_count_bound, aclk, aresetn, {1'b0, count_reg} < PREAMBLE_LEN)
    `ASSERT_CLK(a_body_pending, aclk, aresetn, (phase_reg == PH_BODY) |-> (left_reg != 9'd0))

endmodule

// File: rtl/core/vsfp_out_stage.sv
module vsfp_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  vsfp_pkg::vsfp_result_t res,
    output vsfp_pkg::vsfp_flow_t   flow,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,
    output logic [1:0]            m_tuser
);
    import vsfp_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    vsfp_result_t res_reg;

    // The register can take a new result when empty or being drained.
    assign flow.ready = !valid_reg || m_tready;
    assign flow.valid = valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {res_reg.breath_quality, res_reg.breath_bpm,
                       res_reg.heart_quality, res_reg.heart_bpm,
                       res_reg.move_wave, res_reg.breath_wave, res_reg.heart_wave};

endmodule

// File: rtl/core/vital_sign_frame_parser.sv
// Vital-sign frame parser.
// Input channel s_*: one received serial byte per transfer in s_tdata.
// The parser hunts for the preamble of 128,0 pairs, then reads a type byte,
// a length byte, the payload and cfg_wr_data-configured trailer bytes.
// Output channel m_*: one transfer per completed frame of type 1, 2 or 3,
// with the frame kind in m_tuser and every held sample and rate in m_tdata.
// Unknown frame types are consumed without an output transfer.
// Configuration: cfg_wr_en writes the 2-bit trailer length; write it only
// while the block is idle.
// Throughput is one byte per cycle while the result register has room: each
// byte is parsed combinationally between the input register and the result
// register. The byte that ends a frame waits in the input register; its
// result is loaded into the result register, once free, and sets m_tvalid.
// When m_tready is low the result holds, and the input register takes a
// byte only if empty; when full, s_tready is low until the result is taken.
// Reset clears the parser to the preamble hunt, all held values to zero and
// the trailer length to 2.
module vital_sign_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] heart_wave, [31:16] breath_wave, [47:32] move_wave,
    // [55:48] heart_bpm, [63:56] heart_quality, [71:64] breath_bpm,
    // [79:72] breath_quality
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import vsfp_pkg::*;

    vsfp_flow_t   in_flow;
    vsfp_flow_t   out_flow;
    logic [7:0]   item_byte;
    logic         strobe;
    logic         res_valid;
    vsfp_result_t res;

    // A byte is parsed when it is held and the result register has room.
    assign strobe = in_flow.valid && out_flow.ready;

    vsfp_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .take      (out_flow.ready),
        .flow      (in_flow),
        .item_byte (item_byte)
    );

    vsfp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .strobe      (strobe),
        .rx_byte     (item_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    vsfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .flow     (out_flow),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
